[rtl/tmm_pkg.sv]
`default_nettype none
package tmm_pkg;
    localparam int unsigned MaxDim = 8;
    localparam int unsigned IdxW = 3;
    localparam int unsigned ElemW = 16;
    localparam int unsigned ProdW = 32;
    localparam int unsigned SumW = 40;
    localparam int unsigned CfgW = 4;

    typedef enum logic [1:0] {
        K_LOAD_A = 2'd0,
        K_LOAD_W = 2'd1,
        K_COMPUTE = 2'd2,
        K_NOP = 2'd3
    } t_kind;

    localparam logic [1:0] CfgBatch = 2'd0;
    localparam logic [1:0] CfgInner = 2'd1;
    localparam logic [1:0] CfgOutputs = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IdxW-1:0]  row;
        logic [IdxW-1:0]  col;
    } t_tag;
endpackage
`default_nettype wire

[rtl/tmm_cell.sv]
`default_nettype none
module tmm_cell (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_enable,
    input  wire tmm_pkg::t_tag            i_tag,
    input  wire logic signed [15:0]       i_a,
    input  wire logic signed [15:0]       i_w,
    input  wire logic signed [39:0]       i_sum,
    output tmm_pkg::t_tag                 o_tag,
    output logic signed [39:0]            o_sum
);
    import tmm_pkg::*;

    t_tag                    r_tag;
    logic signed [SumW-1:0]  r_sum;
    logic signed [ProdW-1:0] n_prod;

    assign n_prod = i_a * i_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enable) begin
            r_sum <= i_sum + SumW'(n_prod);
        end else begin
            r_sum <= i_sum;
        end
    end

    assign o_tag = r_tag;
    assign o_sum = r_sum;
endmodule
`default_nettype wire

[rtl/tiled_matrix_multiply_top.sv]
`default_nettype none
// One load transaction is taken per cycle while no compute is in progress. A
// compute transaction issues one result per cycle, except while results are
// stalled, into a chain of MAX_INNER multiply-accumulate cells; the chain runs
// its operands one cell ahead each cycle unless stalled, then through the
// output register. A compute holds the input while it issues and drains, and
// longer while results are stalled; no new transaction is taken until its last
// result has been delivered. Store entries must be written before a compute reads them.
module tiled_matrix_multiply_top #(
    parameter int unsigned MAX_BATCH = 8,
    parameter int unsigned MAX_INNER = 8,
    parameter int unsigned MAX_OUTPUTS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [3:0]           i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_kind,
    input  wire logic [2:0]           i_row_index,
    input  wire logic [2:0]           i_col_index,
    input  wire logic signed [15:0]   i_element_value,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [2:0]                o_result_row,
    output logic [2:0]                o_result_col,
    output logic signed [39:0]        o_result_value,
    output logic                      o_last_result
);
    import tmm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    logic [CfgW-1:0] r_nb, r_ni, r_no;
    logic [IdxW-1:0] nb_m1, ni_m1, no_m1;

    function automatic logic [IdxW-1:0] clamp_m1(input logic [CfgW-1:0] v,
                                                 input logic [CfgW-1:0] m);
        logic [CfgW-1:0] t;
        t = (v == '0) ? CfgW'(1) : ((v > m) ? m : v);
        return IdxW'(t - CfgW'(1));
    endfunction

    assign nb_m1 = clamp_m1(r_nb, CfgW'(MAX_BATCH));
    assign ni_m1 = clamp_m1(r_ni, CfgW'(MAX_INNER));
    assign no_m1 = clamp_m1(r_no, CfgW'(MAX_OUTPUTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb <= CfgW'(8);
            r_ni <= CfgW'(8);
            r_no <= CfgW'(8);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgBatch:   r_nb <= i_cfg_data;
                CfgInner:   r_ni <= i_cfg_data;
                CfgOutputs: r_no <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stores: one bank per inner index so each cell reads its own element.
    logic signed [ElemW-1:0] r_amem [MAX_INNER][MAX_BATCH];
    logic signed [ElemW-1:0] r_wmem [MAX_INNER][MAX_OUTPUTS];

    t_state r_state, n_state;
    logic [IdxW-1:0] r_b, r_o;
    logic            r_hold;
    logic            accept, issue, out_take, chain_go;

    assign o_stall = (r_state != S_IDLE);
    assign accept = i_valid && !o_stall;
    assign out_take = o_valid && !i_stall;
    assign chain_go = !(o_valid && i_stall);
    assign issue = (r_state == S_RUN) && chain_go;

    always_ff @(posedge i_clk) begin
        if (accept && t_kind'(i_kind) == K_LOAD_A) begin
            for (int k = 0; k < MAX_INNER; k++) begin
                if (i_col_index == IdxW'(k) && 32'(i_row_index) < MAX_BATCH)
                    r_amem[k][i_row_index] <= i_element_value;
            end
        end
        if (accept && t_kind'(i_kind) == K_LOAD_W) begin
            for (int k = 0; k < MAX_INNER; k++) begin
                if (i_row_index == IdxW'(k) && 32'(i_col_index) < MAX_OUTPUTS)
                    r_wmem[k][i_col_index] <= i_element_value;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && t_kind'(i_kind) == K_COMPUTE) n_state = S_RUN;
            S_RUN:  if (issue && r_b == nb_m1 && r_o == no_m1) n_state = S_WAIT;
            S_WAIT: if (out_take && o_last_result) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_b <= '0;
            r_o <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_b <= '0;
                r_o <= '0;
            end else if (issue) begin
                if (r_o == no_m1) begin
                    r_o <= '0;
                    r_b <= r_b + IdxW'(1);
                end else begin
                    r_o <= r_o + IdxW'(1);
                end
            end
        end
    end

    // Operand skew: cell k reads its operands with the tag that has passed through
    // the cells before it, so row/col indexes travel with the tags.
    t_tag tag [MAX_INNER+1];
    logic signed [SumW-1:0] sum [MAX_INNER+1];
    t_tag c_tag;

    always_comb begin
        c_tag = '0;
        c_tag.valid = issue;
        c_tag.row = r_b;
        c_tag.col = r_o;
        c_tag.last = (r_b == nb_m1) && (r_o == no_m1);
    end

    assign tag[0] = c_tag;
    assign sum[0] = '0;
    assign r_hold = !chain_go;

    t_tag  r_otag;
    logic signed [SumW-1:0] r_osum;

    generate
        for (genvar k = 0; k < MAX_INNER; k++) begin : g_cell
            t_tag tag_in;
            logic signed [SumW-1:0] sum_in;
            logic en;
            assign tag_in = r_hold ? tag[k+1] : tag[k];
            assign sum_in = r_hold ? sum[k+1] : sum[k];
            assign en = !r_hold && tag[k].valid && (IdxW'(k) <= ni_m1);
            tmm_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_enable (en),
                .i_tag    (tag_in),
                .i_a      (r_amem[k][tag[k].row]),
                .i_w      (r_wmem[k][tag[k].col]),
                .i_sum    (sum_in),
                .o_tag    (tag[k+1]),
                .o_sum    (sum[k+1])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag <= '0;
        end else if (chain_go) begin
            r_otag <= tag[MAX_INNER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_go) r_osum <= sum[MAX_INNER];
    end

    assign o_valid = r_otag.valid;
    assign o_result_row = r_otag.row;
    assign o_result_col = r_otag.col;
    assign o_result_value = r_osum;
    assign o_last_result = r_otag.last;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_valid) else $error("result while idle");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && o_last_result) |=> (r_state == S_IDLE))
        else $error("last result did not end compute");
`endif
endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import tmm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [3:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_kind = '0;
    logic [2:0] i_row_index = '0;
    logic [2:0] i_col_index = '0;
    logic signed [15:0] i_element_value = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_result_row;
    logic [2:0] o_result_col;
    logic signed [39:0] o_result_value;
    logic o_last_result;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic signed [39:0] value;
        logic last;
    } t_product;

    t_product product_queue[$];
    logic signed [15:0] a_matrix[64];
    logic signed [15:0] w_matrix[64];
    bit a_written[64];
    bit w_written[64];
    logic [3:0] size_reg[3];
    int errors = 0;
    int sent_items = 0;
    int checked_results = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    tiled_matrix_multiply_top DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int clamp_dim(logic [3:0] v);
        if (v == 0) return 1;
        if (v > MaxDim) return MaxDim;
        return v;
    endfunction

    task automatic predict_item(t_kind kind, logic [2:0] row, logic [2:0] col,
                                logic signed [15:0] value);
        int nb;
        int ni;
        int no;
        logic signed [39:0] sum;
        t_product p;
        case (kind)
            K_LOAD_A: begin
                a_matrix[row*8+col] = value;
                a_written[row*8+col] = 1;
            end
            K_LOAD_W: begin
                w_matrix[row*8+col] = value;
                w_written[row*8+col] = 1;
            end
            K_COMPUTE: begin
                nb = clamp_dim(size_reg[CfgBatch]);
                ni = clamp_dim(size_reg[CfgInner]);
                no = clamp_dim(size_reg[CfgOutputs]);
                for (int b = 0; b < nb; b++) begin
                    for (int o = 0; o < no; o++) begin
                        sum = 0;
                        for (int i = 0; i < ni; i++) begin
                            sum += 40'(a_matrix[b*8+i]) * 40'(w_matrix[i*8+o]);
                        end
                        p.row = 3'(b);
                        p.col = 3'(o);
                        p.value = sum;
                        p.last = (b == nb - 1) && (o == no - 1);
                        product_queue.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(t_kind kind, logic [2:0] row, logic [2:0] col,
                             logic signed [15:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        predict_item(kind, row, col, value);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_row_index <= row;
        i_col_index <= col;
        i_element_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (product_queue.size() != 0) @(posedge i_clk);
        repeat (MaxDim + 4) @(posedge i_clk);
    endtask

    task automatic write_size(logic [1:0] index, logic [3:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        size_reg[index] = value;
        @(posedge i_clk);
    endtask

    task automatic set_sizes(logic [3:0] nb, logic [3:0] ni, logic [3:0] no);
        wait_idle();
        write_size(CfgBatch, nb);
        write_size(CfgInner, ni);
        write_size(CfgOutputs, no);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_all(bit extreme);
        logic signed [15:0] v;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                v = extreme ? 16'sh8000 : 16'($urandom);
                send_item(K_LOAD_A, 3'(r), 3'(c), v);
                v = extreme ? 16'sh8000 : 16'($urandom);
                send_item(K_LOAD_W, 3'(r), 3'(c), v);
            end
        end
    endtask

    task automatic test_directed();
        set_sizes(4'd8, 4'd8, 4'd8);
        fill_all(1'b1);
        send_item(K_COMPUTE, 3'd0, 3'd0, 16'sd0);
        send_item(K_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
        send_item(K_LOAD_W, 3'd7, 3'd7, 16'sh7fff);
        send_item(K_NOP, 3'd7, 3'd7, 16'shffff);
        set_sizes(4'd0, 4'd15, 4'd1);
        send_item(K_COMPUTE, 3'd7, 3'd7, 16'shffff);
        set_sizes(4'd1, 4'd1, 4'd9);
        send_item(K_COMPUTE, 3'd0, 3'd0, 16'sd0);
    endtask

    task automatic test_random(int count);
        int n;
        int r;
        n = 0;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(K_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
            end else if (r < 15) begin
                send_item(K_NOP, 3'($urandom), 3'($urandom), 16'($urandom));
            end else begin
                send_item(r[0] ? K_LOAD_A : K_LOAD_W, 3'($urandom), 3'($urandom),
                          16'($urandom));
            end
            n++;
            if (n % 12 == 0) begin
                set_sizes(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                          4'($urandom_range(1, 8)));
            end
        end
    endtask

    task automatic test_backpressure();
        set_sizes(4'd2, 4'd8, 4'd3);
        hold_cycles = 200;
        send_item(K_COMPUTE, 3'd0, 3'd0, 16'sd0);
        send_item(K_COMPUTE, 3'd0, 3'd0, 16'sd0);
        send_item(K_LOAD_A, 3'd1, 3'd1, 16'sh1234);
        send_item(K_COMPUTE, 3'd0, 3'd0, 16'sd0);
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_product exp_p;
        if (i_rst_n && o_valid && !i_stall) begin
            if (product_queue.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d value %0d",
                         $time, o_result_row, o_result_col, o_result_value);
                errors++;
            end else begin
                exp_p = product_queue.pop_front();
                checked_results++;
                if (o_result_row !== exp_p.row || o_result_col !== exp_p.col
                        || o_result_value !== exp_p.value
                        || o_last_result !== exp_p.last) begin
                    $display("%0t: expected %0d,%0d %0d last %0b actual %0d,%0d %0d last %0b",
                             $time, exp_p.row, exp_p.col, exp_p.value, exp_p.last,
                             o_result_row, o_result_col, o_result_value, o_last_result);
                    errors++;
                end
            end
        end
    end

    initial begin
        size_reg[0] = 4'd8;
        size_reg[1] = 4'd8;
        size_reg[2] = 4'd8;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 30;
        recv_idle_pct = 48;
        test_directed();
        test_random(24);
        send_idle_pct = 48;
        recv_idle_pct = 30;
        test_random(24);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(24);
        wait_idle();
        $display("Sent %0d transactions and checked %0d results over several tile sizes.",
                 sent_items, checked_results);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
